### sv/lsgcd_pkg.sv
package lsgcd_pkg;

    // field and datapath widths
    localparam int LedIdxW   = 6;
    localparam int LedSlots  = 64;
    localparam int ColorW    = 8;
    localparam int ChanW     = 24;
    localparam int NumChan   = 3;
    localparam int RateW     = 24;
    localparam int McandW    = 32;
    localparam int MulBits   = 24;
    localparam int ProdW     = McandW + MulBits;
    localparam int WeightW   = 17;
    localparam int WMaxDist  = 32;
    localparam int CfgIdxW   = 1;

    // rate register defaults
    localparam logic [RateW-1:0] EffectRateRst = 24'd83886;
    localparam logic [RateW-1:0] DecayRateRst  = 24'd1678;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgEffectRate = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgDecayRate  = 1'b1;

    typedef logic [ChanW-1:0] t_chan;
    typedef logic [NumChan-1:0][ChanW-1:0] t_row;
    typedef logic [WMaxDist:0][WeightW-1:0] t_wtab;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_COEF,
        S_PULL_GO,
        S_PULL,
        S_DECAY_GO,
        S_DECAY,
        S_EMIT
    } t_state;

    // request to the serial multiplier
    typedef struct packed {
        logic              start;
        logic [McandW-1:0] mcand;
        logic [MulBits-1:0] mplier;
    } t_mul_req;

    // channel store access
    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic [LedIdxW-1:0] addr;
        t_row               wdata;
    } t_store_ctl;

    // restoring division, used only while building the weight table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // gaussian weight per ring distance in q16, base exp(-1/(2*s^2)) in q31
    function automatic t_wtab build_weights(input int unsigned spr);
        logic [63:0] s;
        logic [63:0] twos2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        t_wtab       tab;
        s     = 64'(spr);
        twos2 = 64'd2 * s * s;
        term  = 64'h8000_0000;
        sum   = 64'h8000_0000;
        v     = 64'h8000_0000;
        for (int k = 1; k < 24; k++) begin
            term = udiv64(term, 64'(k) * twos2);
            if ((k % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        for (int d = 0; d <= WMaxDist; d++) begin
            tab[d] = WeightW'((udiv64(v, s) + 64'h4000) >> 15);
            for (int r = 0; r < 2 * d + 1; r++) begin
                v = (v * sum + 64'h4000_0000) >> 31;
            end
        end
        return tab;
    endfunction

endpackage

### sv/lsgcd_serial_mult.sv
module lsgcd_serial_mult (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lsgcd_pkg::t_mul_req            i_req,
    output logic                           o_done,
    output logic [lsgcd_pkg::ProdW-1:0]    o_product
);

    localparam int CntW = $clog2(lsgcd_pkg::MulBits);

    logic                             r_busy;
    logic                             r_done;
    logic [CntW-1:0]                  r_cnt;
    logic [lsgcd_pkg::McandW-1:0]     r_mcand;
    logic [lsgcd_pkg::McandW-1:0]     r_hi;
    logic [lsgcd_pkg::MulBits-1:0]    r_lo;
    logic [lsgcd_pkg::McandW:0]       s_sum;

    // add the multiplicand when the low multiplier bit is set
    assign s_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : '0);

    // control: one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CntW'(lsgcd_pkg::MulBits - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // shift-add product register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mcand <= i_req.mcand;
            r_hi    <= '0;
            r_lo    <= i_req.mplier;
        end else if (r_busy) begin
            r_hi <= s_sum[lsgcd_pkg::McandW:1];
            r_lo <= {s_sum[0], r_lo[lsgcd_pkg::MulBits-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

endmodule

### sv/lsgcd_channel_store.sv
module lsgcd_channel_store (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lsgcd_pkg::t_store_ctl   i_ctl,
    output lsgcd_pkg::t_row         o_rdata
);

    lsgcd_pkg::t_row                    r_mem [lsgcd_pkg::LedSlots];
    logic [lsgcd_pkg::LedSlots-1:0]     r_valid;
    lsgcd_pkg::t_row                    r_rdata;
    logic                               r_rvalid;

    // row memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.addr] <= i_ctl.wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_ctl.addr];
        end
    end

    // written marks, an unwritten row reads as black
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_ctl.addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rvalid <= r_valid[i_ctl.addr];
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

### sv/led_strip_gaussian_color_drift_unit.sv
// one input word is a frame tick; one result word per LED comes out, in index order
// a shared bit-serial shift-add multiplier runs seven products per LED, and the LEDs are
// handled one after another, each result registered once its products are done and the output is free;
// no new word is taken while a frame is in progress; the next word
// is taken as soon as the last result of a frame is registered
// synchronous active-low reset: all LEDs black, goal zero, rate registers to defaults
module led_strip_gaussian_color_drift_unit #(
    parameter int LED_COUNT = 60,
    parameter int SPREAD    = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // frame tick
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_new_goal,
    input  logic [lsgcd_pkg::LedIdxW-1:0]       i_goal_position,
    input  logic [lsgcd_pkg::ColorW-1:0]        i_goal_red,
    input  logic [lsgcd_pkg::ColorW-1:0]        i_goal_green,
    input  logic [lsgcd_pkg::ColorW-1:0]        i_goal_blue,
    // per-LED results
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [lsgcd_pkg::LedIdxW-1:0]       o_led_index,
    output logic [lsgcd_pkg::ColorW-1:0]        o_red,
    output logic [lsgcd_pkg::ColorW-1:0]        o_green,
    output logic [lsgcd_pkg::ColorW-1:0]        o_blue,
    output logic                                o_last_led,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [lsgcd_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [lsgcd_pkg::RateW-1:0]         i_cfg_data
);

    localparam int Nled = (LED_COUNT < 1) ? 1 : ((LED_COUNT > 64) ? 64 : LED_COUNT);
    localparam int unsigned Spr = (SPREAD < 1) ? 1 : ((SPREAD > 16) ? 16 : SPREAD);
    localparam int DistW = lsgcd_pkg::LedIdxW + 1;
    localparam logic [DistW-1:0] NledW = DistW'(Nled);
    localparam logic [lsgcd_pkg::LedIdxW-1:0] LastIdx = lsgcd_pkg::LedIdxW'(Nled - 1);
    localparam lsgcd_pkg::t_wtab WeightTab = lsgcd_pkg::build_weights(Spr);

    lsgcd_pkg::t_state                      r_state;
    lsgcd_pkg::t_state                      n_state;
    logic [lsgcd_pkg::LedIdxW-1:0]          r_led;
    logic [1:0]                             r_chan;
    logic [lsgcd_pkg::LedIdxW-1:0]          r_goal_center;
    logic [lsgcd_pkg::NumChan-1:0][lsgcd_pkg::ColorW-1:0] r_goal_rgb;
    logic [lsgcd_pkg::RateW-1:0]            r_eff;
    logic [lsgcd_pkg::RateW-1:0]            r_dec;
    logic [lsgcd_pkg::McandW-1:0]           r_coef;
    lsgcd_pkg::t_row                        r_row;
    lsgcd_pkg::t_chan                       r_cval;
    logic                                   r_out_valid;
    logic [lsgcd_pkg::LedIdxW-1:0]          r_out_idx;
    logic [lsgcd_pkg::ColorW-1:0]           r_out_red;
    logic [lsgcd_pkg::ColorW-1:0]           r_out_green;
    logic [lsgcd_pkg::ColorW-1:0]           r_out_blue;
    logic                                   r_out_last;

    lsgcd_pkg::t_mul_req                    s_mul_req;
    logic                                   s_mul_done;
    logic [lsgcd_pkg::ProdW-1:0]            s_prod;
    lsgcd_pkg::t_store_ctl                  s_store_ctl;
    lsgcd_pkg::t_row                        s_store_rdata;
    logic                                   s_out_free;
    logic                                   s_out_load;
    logic                                   s_accept;
    logic [lsgcd_pkg::LedIdxW-1:0]          s_diff_idx;
    logic [DistW-1:0]                       s_wrap;
    logic [DistW-1:0]                       s_dist;
    logic [lsgcd_pkg::LedIdxW-1:0]          s_widx;
    logic [lsgcd_pkg::WeightW-1:0]          s_weight;
    lsgcd_pkg::t_chan                       s_cur;
    lsgcd_pkg::t_chan                       s_target;
    logic                                   s_up;
    lsgcd_pkg::t_chan                       s_absdiff;
    lsgcd_pkg::t_chan                       s_amt;
    lsgcd_pkg::t_chan                       s_pulled;
    lsgcd_pkg::t_chan                       s_decayed;

    lsgcd_serial_mult u_mult (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (s_mul_req),
        .o_done     (s_mul_done),
        .o_product  (s_prod)
    );

    lsgcd_channel_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (s_store_ctl),
        .o_rdata    (s_store_rdata)
    );

    // ring distance to the goal and weight lookup
    assign s_diff_idx = (r_led > r_goal_center) ? (r_led - r_goal_center)
                                                : (r_goal_center - r_led);
    assign s_wrap     = NledW - {1'b0, s_diff_idx};
    assign s_dist     = (s_wrap < {1'b0, s_diff_idx}) ? s_wrap : {1'b0, s_diff_idx};
    assign s_widx     = (s_dist > DistW'(lsgcd_pkg::WMaxDist))
                      ? lsgcd_pkg::LedIdxW'(lsgcd_pkg::WMaxDist)
                      : s_dist[lsgcd_pkg::LedIdxW-1:0];
    assign s_weight   = WeightTab[s_widx];

    // pull toward goal, then decay
    assign s_cur      = r_row[r_chan];
    assign s_target   = {r_goal_rgb[r_chan], 16'h0000};
    assign s_up       = (s_target >= s_cur);
    assign s_absdiff  = s_up ? (s_target - s_cur) : (s_cur - s_target);
    assign s_amt      = s_prod[lsgcd_pkg::ProdW-1:lsgcd_pkg::McandW];
    assign s_pulled   = s_up ? (s_cur + s_amt) : (s_cur - s_amt);
    assign s_decayed  = r_cval - s_prod[2*lsgcd_pkg::ChanW-1:lsgcd_pkg::ChanW];

    assign s_out_free = !r_out_valid || i_ready;
    assign s_accept   = i_valid && o_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lsgcd_pkg::S_IDLE: begin
                if (i_valid) n_state = lsgcd_pkg::S_START;
            end
            lsgcd_pkg::S_START: begin
                n_state = lsgcd_pkg::S_COEF;
            end
            lsgcd_pkg::S_COEF: begin
                if (s_mul_done) n_state = lsgcd_pkg::S_PULL_GO;
            end
            lsgcd_pkg::S_PULL_GO: begin
                n_state = lsgcd_pkg::S_PULL;
            end
            lsgcd_pkg::S_PULL: begin
                if (s_mul_done) n_state = lsgcd_pkg::S_DECAY_GO;
            end
            lsgcd_pkg::S_DECAY_GO: begin
                n_state = lsgcd_pkg::S_DECAY;
            end
            lsgcd_pkg::S_DECAY: begin
                if (s_mul_done) begin
                    n_state = (r_chan == 2'(lsgcd_pkg::NumChan - 1))
                            ? lsgcd_pkg::S_EMIT : lsgcd_pkg::S_PULL_GO;
                end
            end
            lsgcd_pkg::S_EMIT: begin
                if (s_out_free) begin
                    n_state = (r_led == LastIdx) ? lsgcd_pkg::S_IDLE : lsgcd_pkg::S_START;
                end
            end
            default: begin
                n_state = lsgcd_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs: multiplier requests, store access, result load
    always_comb begin
        o_ready           = 1'b0;
        s_mul_req         = '0;
        s_store_ctl       = '0;
        s_store_ctl.addr  = r_led;
        s_store_ctl.wdata = r_row;
        s_out_load        = 1'b0;
        case (r_state)
            lsgcd_pkg::S_IDLE: begin
                o_ready = 1'b1;
            end
            lsgcd_pkg::S_START: begin
                s_mul_req.start   = 1'b1;
                s_mul_req.mcand   = lsgcd_pkg::McandW'(s_weight);
                s_mul_req.mplier  = r_eff;
                s_store_ctl.rd_en = 1'b1;
            end
            lsgcd_pkg::S_PULL_GO: begin
                s_mul_req.start  = 1'b1;
                s_mul_req.mcand  = r_coef;
                s_mul_req.mplier = s_absdiff;
            end
            lsgcd_pkg::S_DECAY_GO: begin
                s_mul_req.start  = 1'b1;
                s_mul_req.mcand  = lsgcd_pkg::McandW'(r_cval);
                s_mul_req.mplier = r_dec;
            end
            lsgcd_pkg::S_EMIT: begin
                s_store_ctl.wr_en = s_out_free;
                s_out_load        = s_out_free;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= lsgcd_pkg::S_IDLE;
            r_led         <= '0;
            r_chan        <= '0;
            r_goal_center <= '0;
            r_goal_rgb    <= '0;
            r_eff         <= lsgcd_pkg::EffectRateRst;
            r_dec         <= lsgcd_pkg::DecayRateRst;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lsgcd_pkg::CfgEffectRate: r_eff <= i_cfg_data;
                    lsgcd_pkg::CfgDecayRate:  r_dec <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // frame start, goal load with saturation to the last LED
            if (s_accept) begin
                r_led <= '0;
                if (i_new_goal) begin
                    r_goal_center <= ({1'b0, i_goal_position} >= NledW) ? LastIdx
                                                                        : i_goal_position;
                    r_goal_rgb    <= {i_goal_blue, i_goal_green, i_goal_red};
                end
            end

            // channel walk
            if (r_state == lsgcd_pkg::S_COEF && s_mul_done) begin
                r_chan <= '0;
            end
            if (r_state == lsgcd_pkg::S_DECAY && s_mul_done
                    && r_chan != 2'(lsgcd_pkg::NumChan - 1)) begin
                r_chan <= r_chan + 1'b1;
            end

            // LED walk
            if (r_state == lsgcd_pkg::S_EMIT && s_out_free && r_led != LastIdx) begin
                r_led <= r_led + 1'b1;
            end

            // result register
            if (s_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == lsgcd_pkg::S_COEF && s_mul_done) begin
            r_coef <= s_prod[lsgcd_pkg::McandW+7:8];
            r_row  <= s_store_rdata;
        end
        if (r_state == lsgcd_pkg::S_PULL && s_mul_done) begin
            r_cval <= s_pulled;
        end
        if (r_state == lsgcd_pkg::S_DECAY && s_mul_done) begin
            r_row[r_chan] <= s_decayed;
        end
        if (s_out_load) begin
            r_out_idx   <= r_led;
            r_out_red   <= r_row[0][lsgcd_pkg::ChanW-1:16];
            r_out_green <= r_row[1][lsgcd_pkg::ChanW-1:16];
            r_out_blue  <= r_row[2][lsgcd_pkg::ChanW-1:16];
            r_out_last  <= (r_led == LastIdx);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_led_index = r_out_idx;
    assign o_red       = r_out_red;
    assign o_green     = r_out_green;
    assign o_blue      = r_out_blue;
    assign o_last_led  = r_out_last;

    // an accepted word always starts the LED walk
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == lsgcd_pkg::S_START))
        else $error("accepted word did not start the LED walk");

    // the last LED of a frame returns the block to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_out_load && r_led == LastIdx) |=> (r_state == lsgcd_pkg::S_IDLE))
        else $error("block not idle after last LED result");

    // a product only completes while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_mul_done |-> (r_state == lsgcd_pkg::S_COEF || r_state == lsgcd_pkg::S_PULL
                        || r_state == lsgcd_pkg::S_DECAY))
        else $error("multiplier finished outside a wait state");

endmodule

### dv/led_strip_gaussian_color_drift_unit_tb.sv
module led_strip_gaussian_color_drift_unit_tb;
    import lsgcd_pkg::*;

    localparam int LEDS     = 60;
    localparam int SPREAD_V = 4;

    typedef struct packed {
        logic               new_goal;
        logic [LedIdxW-1:0] pos;
        logic [ColorW-1:0]  red;
        logic [ColorW-1:0]  green;
        logic [ColorW-1:0]  blue;
    } frame_t;

    typedef struct packed {
        logic [LedIdxW-1:0] idx;
        logic [ColorW-1:0]  red;
        logic [ColorW-1:0]  green;
        logic [ColorW-1:0]  blue;
        logic               last;
    } led_word_t;

    typedef enum int {RDY_OPEN, RDY_RANDOM, RDY_PATTERN} rx_mode_e;

    // ring state mirror: predicts every LED word of a frame, checks them in order
    class drift_scoreboard;
        logic [WeightW-1:0] wtab [WMaxDist+1];
        logic [ChanW-1:0]   chan [LEDS][NumChan];
        logic [ColorW-1:0]  goal_rgb [NumChan];
        logic [LedIdxW-1:0] goal_center;
        logic [RateW-1:0]   effect_rate;
        logic [RateW-1:0]   decay_rate;
        led_word_t          due_leds [$];
        int                 frames;
        int                 leds_checked;
        int                 errors;

        function new();
            longint unsigned s, twos2, term, base, v;
            s     = SPREAD_V;
            twos2 = 2 * s * s;
            term  = 64'd1 << 31;
            base  = 64'd1 << 31;
            // exp(-1/(2*s^2)) in q31 by alternating series
            for (int k = 1; k < 24; k++) begin
                term = term / (longint'(k) * twos2);
                if (k % 2 == 1) begin
                    base = base - term;
                end else begin
                    base = base + term;
                end
            end
            // weight per distance: running value advanced by base^(2d+1)
            v = 64'd1 << 31;
            for (int d = 0; d <= WMaxDist; d++) begin
                wtab[d] = WeightW'(((v / s) + 64'h4000) >> 15);
                for (int r = 0; r < 2 * d + 1; r++) begin
                    v = (v * base + 64'h4000_0000) >> 31;
                end
            end
            foreach (chan[i, p]) chan[i][p] = '0;
            foreach (goal_rgb[p]) goal_rgb[p] = '0;
            goal_center  = '0;
            effect_rate  = EffectRateRst;
            decay_rate   = DecayRateRst;
            frames       = 0;
            leds_checked = 0;
            errors       = 0;
        endfunction

        function void set_rate(logic [CfgIdxW-1:0] idx, logic [RateW-1:0] val);
            if (idx == CfgEffectRate) begin
                effect_rate = val;
            end else if (idx == CfgDecayRate) begin
                decay_rate = val;
            end
        endfunction

        // one frame tick: optional goal load, then pull and decay of every LED
        function void advance_frame(frame_t f);
            int unsigned     d, ring_dist;
            longint unsigned coef, c, tgt, amt;
            led_word_t       w;
            frames++;
            if (f.new_goal) begin
                goal_center = (f.pos >= LEDS) ? LedIdxW'(LEDS - 1) : f.pos;
                goal_rgb[0] = f.red;
                goal_rgb[1] = f.green;
                goal_rgb[2] = f.blue;
            end
            for (int i = 0; i < LEDS; i++) begin
                d         = (i > goal_center) ? i - goal_center : goal_center - i;
                ring_dist = (LEDS - d < d) ? LEDS - d : d;
                if (ring_dist > WMaxDist) ring_dist = WMaxDist;
                coef = (longint'(wtab[ring_dist]) * longint'(effect_rate)) >> 8;
                for (int p = 0; p < NumChan; p++) begin
                    c   = chan[i][p];
                    tgt = longint'(goal_rgb[p]) << 16;
                    if (tgt >= c) begin
                        amt = ((tgt - c) * coef) >> 32;
                        c   = c + amt;
                    end else begin
                        amt = ((c - tgt) * coef) >> 32;
                        c   = c - amt;
                    end
                    c = c - ((c * longint'(decay_rate)) >> 24);
                    chan[i][p] = ChanW'(c);
                end
                w.idx   = LedIdxW'(i);
                w.red   = chan[i][0][ChanW-1:16];
                w.green = chan[i][1][ChanW-1:16];
                w.blue  = chan[i][2][ChanW-1:16];
                w.last  = (i == LEDS - 1);
                due_leds.push_back(w);
            end
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_led(led_word_t got);
            led_word_t want;
            if (due_leds.size() == 0) begin
                errors++;
                $error("LED word idx %0d with none outstanding", got.idx);
                return;
            end
            want = due_leds.pop_front();
            leds_checked++;
            cmp_field("led_index", want.idx, got.idx);
            cmp_field("red", want.red, got.red);
            cmp_field("green", want.green, got.green);
            cmp_field("blue", want.blue, got.blue);
            cmp_field("last_led", want.last, got.last);
        endfunction

        function int pending();
            return due_leds.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic                 i_new_goal;
    logic [LedIdxW-1:0]   i_goal_position;
    logic [ColorW-1:0]    i_goal_red;
    logic [ColorW-1:0]    i_goal_green;
    logic [ColorW-1:0]    i_goal_blue;
    logic                 o_valid;
    logic                 i_ready;
    logic [LedIdxW-1:0]   o_led_index;
    logic [ColorW-1:0]    o_red;
    logic [ColorW-1:0]    o_green;
    logic [ColorW-1:0]    o_blue;
    logic                 o_last_led;
    logic                 i_cfg_we;
    logic [CfgIdxW-1:0]   i_cfg_index;
    logic [RateW-1:0]     i_cfg_data;

    drift_scoreboard board;
    int              burst_left;
    int              rate_writes;
    rx_mode_e        ready_mode;
    int              ready_epoch;
    logic [31:0]     ready_pat;

    led_strip_gaussian_color_drift_unit #(
        .LED_COUNT (LEDS),
        .SPREAD    (SPREAD_V)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_new_goal      (i_new_goal),
        .i_goal_position (i_goal_position),
        .i_goal_red      (i_goal_red),
        .i_goal_green    (i_goal_green),
        .i_goal_blue     (i_goal_blue),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_led_index     (o_led_index),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_last_led      (o_last_led),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #60_000_000;
        $display("Verification failed");
        $finish;
    end

    // result side back-pressure: open, random or rotating pattern, re-picked per epoch
    always @(negedge i_clk) begin
        if (ready_epoch == 0) begin
            ready_mode  = rx_mode_e'($urandom_range(0, 2));
            ready_epoch = $urandom_range(200, 3000);
            ready_pat   = $urandom() | 32'h1;
        end
        ready_epoch--;
        case (ready_mode)
            RDY_OPEN: begin
                i_ready = 1'b1;
            end
            RDY_RANDOM: begin
                i_ready = ($urandom_range(0, 3) != 0);
            end
            default: begin
                i_ready   = ready_pat[0];
                ready_pat = {ready_pat[0], ready_pat[31:1]};
            end
        endcase
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            board.check_led({o_led_index, o_red, o_green, o_blue, o_last_led});
        end
    end

    function automatic frame_t make_frame(logic ng, logic [LedIdxW-1:0] pos,
                                          logic [ColorW-1:0] r, logic [ColorW-1:0] g,
                                          logic [ColorW-1:0] b);
        frame_t f;
        f.new_goal = ng;
        f.pos      = pos;
        f.red      = r;
        f.green    = g;
        f.blue     = b;
        return f;
    endfunction

    function automatic logic [ColorW-1:0] rand_color();
        if ($urandom_range(0, 5) == 0) begin
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
        end
        return ColorW'($urandom());
    endfunction

    function automatic logic [RateW-1:0] rand_rate(bit for_decay);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return for_decay ? DecayRateRst : EffectRateRst;
            default: begin
                // strong decay just blacks the strip, so keep it mostly gentle
                if (for_decay) return RateW'($urandom_range(0, 3000));
                return RateW'($urandom());
            end
        endcase
    endfunction

    // drive one frame word and hold it until taken
    task automatic send_frame(input frame_t f);
        @(negedge i_clk);
        i_valid         = 1'b1;
        i_new_goal      = f.new_goal;
        i_goal_position = f.pos;
        i_goal_red      = f.red;
        i_goal_green    = f.green;
        i_goal_blue     = f.blue;
        do @(posedge i_clk); while (!o_ready);
        board.advance_frame(f);
    endtask

    task automatic idle_sender(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // bursts of back-to-back words separated by random gaps
    task automatic push_frame(input frame_t f);
        if (burst_left == 0) begin
            idle_sender($urandom_range(1, 40));
            burst_left = $urandom_range(1, 6);
        end
        send_frame(f);
        burst_left--;
    endtask

    // stop sending and let every outstanding LED word come out
    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        burst_left = 0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_rate(input logic [CfgIdxW-1:0] idx, input logic [RateW-1:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        board.set_rate(idx, val);
        rate_writes++;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        frame_t f;
        board           = new();
        burst_left      = 0;
        rate_writes     = 0;
        ready_epoch     = 0;
        ready_mode      = RDY_OPEN;
        ready_pat       = 32'h1;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_ready         = 1'b0;
        i_new_goal      = 1'b0;
        i_goal_position = '0;
        i_goal_red      = '0;
        i_goal_green    = '0;
        i_goal_blue     = '0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CfgEffectRate;
        i_cfg_data      = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // default rates: no goal yet, then goals at both ends and past the strip end
        push_frame(make_frame(1'b0, 6'd63, 8'hFF, 8'hFF, 8'hFF));
        push_frame(make_frame(1'b1, 6'd0, 8'hFF, 8'hFF, 8'hFF));
        push_frame(make_frame(1'b0, 6'd0, 8'h00, 8'h00, 8'h00));
        push_frame(make_frame(1'b1, 6'd63, 8'hFF, 8'h00, 8'h80));
        push_frame(make_frame(1'b1, 6'd60, 8'h00, 8'hFF, 8'h00));
        push_frame(make_frame(1'b1, 6'd59, 8'd10, 8'd20, 8'd30));
        drain_results();

        // full pull, no decay: channels run up to the goal and back down
        write_rate(CfgEffectRate, '1);
        write_rate(CfgDecayRate, '0);
        push_frame(make_frame(1'b1, 6'd30, 8'hFF, 8'hFF, 8'hFF));
        push_frame(make_frame(1'b0, 6'd30, 8'h00, 8'h00, 8'h00));
        push_frame(make_frame(1'b1, 6'd0, 8'h00, 8'h00, 8'h00));
        push_frame(make_frame(1'b1, 6'd45, 8'hAA, 8'h55, 8'hFF));
        push_frame(make_frame(1'b0, 6'd21, 8'h55, 8'hAA, 8'h00));
        drain_results();

        // no pull, full decay: fade to black
        write_rate(CfgEffectRate, '0);
        write_rate(CfgDecayRate, '1);
        push_frame(make_frame(1'b0, 6'd0, 8'h00, 8'h00, 8'h00));
        push_frame(make_frame(1'b1, 6'd15, 8'hFF, 8'hFF, 8'hFF));
        drain_results();

        // both at full, then both off so the strip holds
        write_rate(CfgEffectRate, '1);
        push_frame(make_frame(1'b1, 6'd7, 8'hFF, 8'h80, 8'h01));
        push_frame(make_frame(1'b0, 6'd7, 8'h00, 8'h00, 8'h00));
        drain_results();
        write_rate(CfgEffectRate, 24'hC00000);
        write_rate(CfgDecayRate, '0);
        push_frame(make_frame(1'b1, 6'd52, 8'hFE, 8'h7F, 8'h33));
        push_frame(make_frame(1'b0, 6'd52, 8'h00, 8'h00, 8'h00));
        drain_results();
        write_rate(CfgEffectRate, '0);
        push_frame(make_frame(1'b0, 6'd52, 8'h00, 8'h00, 8'h00));
        drain_results();

        // random phases: new rates while idle, then goal changes with steady runs between
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 0) begin
                write_rate(CfgEffectRate, EffectRateRst);
                write_rate(CfgDecayRate, DecayRateRst);
            end else begin
                write_rate(CfgEffectRate, rand_rate(1'b0));
                write_rate(CfgDecayRate, rand_rate(1'b1));
            end
            for (int n = 0; n < 60; n++) begin
                f = make_frame($urandom_range(0, 99) < 35, LedIdxW'($urandom()),
                               rand_color(), rand_color(), rand_color());
                push_frame(f);
                // now and then hold off until the strip is fully reported
                if ($urandom_range(0, 39) == 0) drain_results();
            end
            drain_results();
        end

        repeat (400) @(posedge i_clk);
        $display("Ran %0d frame ticks over %0d rate writes, %0d LED words checked",
                 board.frames, rate_writes, board.leds_checked);
        $display("Goals covered both strip ends, positions past the end, full and zero rates");
        if (board.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
